@@ src/itoa_pkg.sv @@
// Shared constants, codes and digit table of the integer-to-ASCII formatter.
`default_nettype none
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned DIGIT_W = 4;

  localparam logic OP_HEX = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic [CHAR_W-1:0] ASCII_DIGIT [0:15] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

endpackage
`default_nettype wire

@@ src/itoa_dabble.sv @@
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`default_nettype none
module itoa_dabble #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
  parameter int unsigned DEC_DIGITS = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [VALUE_BITS-1:0]        value_i,
  output logic                              done_o,
  output logic [DEC_DIGITS*itoa_pkg::DIGIT_W-1:0] bcd_o
);

  localparam int unsigned BCD_W = DEC_DIGITS * itoa_pkg::DIGIT_W;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = CNT_W'(VALUE_BITS);
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
`default_nettype wire

@@ src/integer_to_ascii_formatter_unit.sv @@
// Top level of the integer-to-ASCII formatter: sequencer, digit shifter and output register.
// Hex word: leading zero digits are skipped while more than two digits remain, then the digits
// are emitted one per cycle while the output is not stalled, the most significant first.
// Decimal word: the BCD converter runs first, then leading zeros are skipped while more than
// one digit remains, and the digits are emitted in the same way.
// A new word is taken only when idle; reset clears the sequencer and the output valid.
`default_nettype none
module integer_to_ascii_formatter_unit #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [VALUE_BITS-1:0]         value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]        character_o,
  output logic                               last_o
);

  localparam int unsigned DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int unsigned MAX_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int unsigned DIG_W = MAX_DIGITS * itoa_pkg::DIGIT_W;
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [DIG_W-1:0]            dig_q, dig_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        op_q, op_d;
  logic [CNT_W-1:0]            min_cnt;
  logic [3:0]                  top_digit;
  logic                        in_take;
  logic                        out_free;
  logic                        dab_done;
  logic [DEC_DIGITS*itoa_pkg::DIGIT_W-1:0] dab_bcd;
  logic                        ov_q, ov_d;
  logic [itoa_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        last_q, last_d;

  itoa_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DEC_DIGITS (DEC_DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_take && (opcode_i == itoa_pkg::OP_DEC)),
    .value_i (value_i),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  assign top_digit  = dig_q[DIG_W-1 -: 4];
  assign min_cnt    = (op_q == itoa_pkg::OP_HEX) ? CNT_W'(2) : CNT_W'(1);

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    ov_d    = ov_q && out_stall_i;
    char_d  = char_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          op_d = opcode_i;
          if (opcode_i == itoa_pkg::OP_HEX) begin
            dig_d   = DIG_W'(value_i) << ((MAX_DIGITS - HEX_DIGITS) * 4);
            cnt_d   = CNT_W'(HEX_DIGITS);
            state_d = ST_SKIP;
          end else begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          dig_d   = DIG_W'(dab_bcd) << ((MAX_DIGITS - DEC_DIGITS) * 4);
          cnt_d   = CNT_W'(DEC_DIGITS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((cnt_q > min_cnt) && (top_digit == 4'd0)) begin
          dig_d = dig_q << 4;
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          char_d = itoa_pkg::ASCII_DIGIT[top_digit];
          last_d = (cnt_q == CNT_W'(1));
          dig_d  = dig_q << 4;
          cnt_d  = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    op_q   <= op_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> (state_q == ST_CONV))
    else $error("converter finished outside conversion");

  a_take_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q != ST_IDLE))
    else $error("accepted word left sequencer idle");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0))
    else $error("emit with no digits left");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((character_o >= 7'h30 && character_o <= 7'h39) ||
                     (character_o >= 7'h41 && character_o <= 7'h46)))
    else $error("output is not a digit");

endmodule
`default_nettype wire

@@ tb/ascii_digit_monitor.sv @@
// Watches both channels of the formatter, predicts each digit string and compares it.
`timescale 1ns / 100ps
module ascii_digit_monitor #(
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic                          opcode_i,
  input  wire logic [VALUE_BITS-1:0]         value_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [itoa_pkg::CHAR_W-1:0]   character_i,
  input  wire logic                          last_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam logic [itoa_pkg::CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [itoa_pkg::CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
  localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] code;
    logic                        last;
  } ascii_digit_t;

  ascii_digit_t pending_digits[$];
  ascii_digit_t want;

  function automatic logic [itoa_pkg::CHAR_W-1:0] digit_code(
    input logic [itoa_pkg::DIGIT_W-1:0] d);
    if (d < 10) return ASCII_ZERO + itoa_pkg::CHAR_W'(d);
    return ASCII_UPPER_A + itoa_pkg::CHAR_W'(d - 10);
  endfunction

  task automatic push_digit(input logic [itoa_pkg::DIGIT_W-1:0] d, input logic is_last);
    ascii_digit_t c;
    c.code = digit_code(d);
    c.last = is_last;
    pending_digits.push_back(c);
  endtask

  task automatic format_word(input logic op, input logic [VALUE_BITS-1:0] v);
    int top;
    logic [VALUE_BITS-1:0] rest;
    logic [itoa_pkg::DIGIT_W-1:0] dec_digits[$];
    top = 0;
    if (op == itoa_pkg::OP_HEX) begin
      if (v < 16) begin
        push_digit('0, 1'b0);
        push_digit(itoa_pkg::DIGIT_W'(v), 1'b1);
      end else begin
        for (int i = HEX_DIGITS - 1; i > 0; i--) begin
          if (itoa_pkg::DIGIT_W'(v >> (4 * i)) != 0) begin
            top = i;
            break;
          end
        end
        for (int i = top; i >= 0; i--) push_digit(itoa_pkg::DIGIT_W'(v >> (4 * i)), i == 0);
      end
    end else begin
      if (v == 0) begin
        push_digit('0, 1'b1);
      end else begin
        rest = v;
        while (rest != 0) begin
          dec_digits.push_front(itoa_pkg::DIGIT_W'(rest % 10));
          rest = rest / 10;
        end
        foreach (dec_digits[i]) push_digit(dec_digits[i], i == dec_digits.size() - 1);
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual char %h last %b",
                   $time, character_i, last_i);
          fail_count_o++;
        end else begin
          want = pending_digits.pop_front();
          if (character_i !== want.code) begin
            $display("%0t: character mismatch: expected %h (%s), actual %h (%s)",
                     $time, want.code, want.code, character_i, character_i);
            fail_count_o++;
          end
          if (last_i !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, last_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) format_word(opcode_i, value_i);
      pending_o = pending_digits.size();
    end
  end
endmodule

@@ tb/integer_to_ascii_formatter_unit_test.sv @@
// Testbench top for the integer-to-ASCII formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module integer_to_ascii_formatter_unit_test;

  localparam int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_WORDS = 150;
  localparam logic [VALUE_BITS-1:0] CORNER_VALUES [12] = '{
    32'd0, 32'd1, 32'd10, 32'd15, 32'd16, 32'd100, 32'd255, 32'd256,
    32'd999999999, 32'd1000000000, 32'h80000000, 32'hFFFFFFFF
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic opcode = itoa_pkg::OP_HEX;
  logic [VALUE_BITS-1:0] value = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [itoa_pkg::CHAR_W-1:0] character;
  logic last;
  logic in_fired = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count;
  int pending;

  integer_to_ascii_formatter_unit #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .opcode_i   (opcode),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .character_o(character),
    .last_o     (last)
  );

  ascii_digit_monitor #(.VALUE_BITS(VALUE_BITS)) digit_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .opcode_i    (opcode),
    .value_i     (value),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .character_i (character),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    in_fired <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = $urandom_range(99) < recv_stall_pct;
    end
  end

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [63:0] p;
    int k;
    p = 64'd1;
    case ($urandom_range(7))
      0: return VALUE_BITS'($urandom_range(20));
      1: begin
        k = $urandom_range(1, 9);
        repeat (k) p = p * 10;
        return VALUE_BITS'(p + $urandom_range(2) - 1);
      end
      2: begin
        p = p << (4 * $urandom_range(1, 7));
        return VALUE_BITS'(p + $urandom_range(2) - 1);
      end
      default: return VALUE_BITS'($urandom >> $urandom_range(31));
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      opcode = 1'($urandom);
      value = VALUE_BITS'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    value = v;
    do @(negedge clk); while (!in_fired);
    in_valid = 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 23;
    recv_stall_pct = 67;
    foreach (CORNER_VALUES[i]) begin
      send_word(itoa_pkg::OP_HEX, CORNER_VALUES[i]);
      send_word(itoa_pkg::OP_DEC, CORNER_VALUES[i]);
    end
    repeat (PHASE_WORDS) send_word(1'($urandom), pick_value());

    send_idle_pct = 67;
    recv_stall_pct = 23;
    repeat (PHASE_WORDS) send_word(1'($urandom), pick_value());

    // stall the output for a long stretch while words keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (PHASE_WORDS - 4) send_word(1'($urandom), pick_value());

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
